/* hw/rtl/fppid_pkg.sv */
// shared widths, register indexes and reset values of the pid regulator
`timescale 1ns / 1ps

package fppid_pkg;

    // data path widths
    localparam int DATA_W     = 16;
    localparam int GAIN_W     = 15;
    localparam int PROD_W     = 32;
    localparam int INTEG_W    = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT  = 3'd4;

    // operating modes
    localparam logic MODE_PARALLEL = 1'b0;
    localparam logic MODE_SERIES   = 1'b1;

    // reset values of the registers
    localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = 15'd32767;
    localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = 15'd6000;
    localparam logic [GAIN_W-1:0] RST_DERIV_GAIN = 15'd0;
    localparam logic [GAIN_W-1:0] RST_OUT_LIMIT  = 15'd32767;

endpackage

/* hw/rtl/fppid_in_if.sv */
// input channel: target and measured value per beat
`timescale 1ns / 1ps

interface fppid_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [fppid_pkg::DATA_W-1:0] target;
    logic signed [fppid_pkg::DATA_W-1:0] measured;

    modport source (output valid, output target, output measured, input ready);
    modport sink   (input valid, input target, input measured, output ready);
endinterface

/* hw/rtl/fppid_out_if.sv */
// output channel: saturated drive and clip flag per beat
`timescale 1ns / 1ps

interface fppid_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fppid_pkg::DATA_W-1:0] drive;
    logic                                clipped;

    modport source (output valid, output drive, output clipped, input ready);
    modport sink   (input valid, input drive, input clipped, output ready);
endinterface

/* hw/rtl/fppid_mul.sv */
// shared registered multiplier: unsigned gain times signed sample
`timescale 1ns / 1ps

module fppid_mul (
    input  logic                                 i_clk,
    input  logic        [fppid_pkg::GAIN_W-1:0]  i_gain,
    input  logic signed [fppid_pkg::DATA_W-1:0]  i_sample,
    output logic signed [fppid_pkg::PROD_W-1:0]  o_prod
);

    logic signed [fppid_pkg::GAIN_W:0]   w_gain_s;
    logic signed [fppid_pkg::PROD_W-1:0] r_prod;
    logic signed [fppid_pkg::PROD_W-1:0] n_prod;

    // gain is positive, widen with a zero sign bit
    assign w_gain_s = $signed({1'b0, i_gain});

    // operands extend to the product width before the multiply
    always_comb begin
        n_prod = w_gain_s * i_sample;
    end

    // product register, one multiply per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

/* hw/rtl/fixed_point_pid_regulator_top.sv */
// Q15 pid regulator with clamped integrator, sequencing one shared multiplier
// A small sequencer steps the single 16x16 multiplier through the
// proportional, integral and derivative products, then clamps the integrator
// against its upper and lower bound, sums and saturates. Input is taken only
// while the sequencer is idle, so no new item is taken before the last is
// through; the result is loaded once the previous one has been taken, and a
// result waiting in the output register does not block acceptance of the next
// item. Registers are written through the plain write port (index 0 mode,
// 1 prop_gain, 2 integ_gain, 3 deriv_gain, 4 out_limit); writes to other
// indexes are ignored. The user must write them only while no item is in
// flight; the block itself does not enforce this.
`timescale 1ns / 1ps

module fixed_point_pid_regulator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    fppid_in_if.sink                            i_in,
    fppid_out_if.source                         o_out,
    input  logic                                i_cfg_we,
    input  logic [fppid_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fppid_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int DW = fppid_pkg::DATA_W;
    localparam int GW = fppid_pkg::GAIN_W;
    localparam int IW = fppid_pkg::INTEG_W;
    localparam int PW = fppid_pkg::PROD_W;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MP   = 3'd1;
    localparam logic [2:0] S_MI   = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_CHI  = 3'd4;
    localparam logic [2:0] S_CLO  = 3'd5;
    localparam logic [2:0] S_SUM  = 3'd6;
    localparam logic [2:0] S_SAT  = 3'd7;

    // configuration registers
    logic          r_mode;
    logic [GW-1:0] r_kp;
    logic [GW-1:0] r_ki;
    logic [GW-1:0] r_kd;
    logic [GW-1:0] r_lim;

    // control and state
    logic [2:0]            r_state,    n_state;
    logic                  r_out_valid, n_out_valid;
    logic signed [IW-1:0]  r_integ,    n_integ;
    logic signed [DW-1:0]  r_prev_err, n_prev_err;

    // payload registers
    logic signed [DW-1:0]  r_err,      n_err;
    logic signed [DW-1:0]  r_p,        n_p;
    logic signed [DW-1:0]  r_d,        n_d;
    logic signed [DW:0]    r_room,     n_room;
    logic signed [DW+1:0]  r_sum,      n_sum;
    logic signed [DW-1:0]  r_out_drive, n_out_drive;
    logic                  r_out_clip,  n_out_clip;

    // shared multiplier operands
    logic        [GW-1:0]  w_mul_gain;
    logic signed [DW-1:0]  w_mul_sample;
    logic signed [PW-1:0]  w_prod;
    logic signed [DW-1:0]  w_diff;

    // working values
    logic signed [DW:0]    w_p_ext;
    logic signed [DW:0]    w_p_abs;
    logic signed [IW:0]    w_bound;
    logic signed [IW:0]    w_nbound;
    logic signed [IW:0]    w_integ_ext;
    logic signed [DW+1:0]  w_lim_ext;
    logic                  w_in_fire;
    logic                  w_out_fire;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = r_out_valid && o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign o_out.valid   = r_out_valid;
    assign o_out.drive   = r_out_drive;
    assign o_out.clipped = r_out_clip;

    assign w_diff = r_err - r_prev_err;

    // multiplier operand select
    always_comb begin
        case (r_state)
            S_MP: begin
                w_mul_gain   = r_kp;
                w_mul_sample = r_err;
            end
            S_MI: begin
                w_mul_gain   = r_ki;
                w_mul_sample = (r_mode == fppid_pkg::MODE_SERIES) ? w_prod[PW-1:PW-DW] : r_err;
            end
            S_ACC: begin
                w_mul_gain   = r_kd;
                w_mul_sample = w_diff;
            end
            default: begin
                w_mul_gain   = r_kp;
                w_mul_sample = r_err;
            end
        endcase
    end

    fppid_mul u_mul (
        .i_clk    (i_clk),
        .i_gain   (w_mul_gain),
        .i_sample (w_mul_sample),
        .o_prod   (w_prod)
    );

    // integrator bound from the proportional headroom
    assign w_p_ext     = {r_p[DW-1], r_p};
    assign w_p_abs     = r_p[DW-1] ? -w_p_ext : w_p_ext;
    assign w_bound     = {r_room, {DW{1'b0}}};
    assign w_nbound    = -w_bound;
    assign w_integ_ext = {r_integ[IW-1], r_integ};
    assign w_lim_ext   = $signed({3'b000, r_lim});

    // sequencer and data path next values
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_integ     = r_integ;
        n_prev_err  = r_prev_err;
        n_err       = r_err;
        n_p         = r_p;
        n_d         = r_d;
        n_room      = r_room;
        n_sum       = r_sum;
        n_out_drive = r_out_drive;
        n_out_clip  = r_out_clip;

        if (w_out_fire) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_err   = i_in.target - i_in.measured;
                    n_state = S_MP;
                end
            end
            S_MP: begin
                n_state = S_MI;
            end
            S_MI: begin
                n_p     = w_prod[PW-1:PW-DW];
                n_state = S_ACC;
            end
            S_ACC: begin
                n_integ = r_integ + w_prod;
                n_room  = $signed({2'b00, r_lim}) - w_p_abs;
                n_state = S_CHI;
            end
            S_CHI: begin
                if (w_integ_ext > w_bound) begin
                    n_integ = w_bound[IW-1:0];
                end
                if (r_mode == fppid_pkg::MODE_PARALLEL) begin
                    n_d        = w_prod[PW-1:PW-DW];
                    n_prev_err = r_err;
                end else begin
                    n_d = '0;
                end
                n_state = S_CLO;
            end
            S_CLO: begin
                if (w_integ_ext < w_nbound) begin
                    n_integ = w_nbound[IW-1:0];
                end
                n_state = S_SUM;
            end
            S_SUM: begin
                n_sum = {{2{r_p[DW-1]}}, r_p}
                      + {{2{r_integ[IW-1]}}, r_integ[IW-1:IW-DW]}
                      + {{2{r_d[DW-1]}}, r_d};
                n_state = S_SAT;
            end
            S_SAT: begin
                // load the output register once it is free
                if (!r_out_valid || o_out.ready) begin
                    if (r_sum > w_lim_ext) begin
                        n_out_drive = $signed({1'b0, r_lim});
                        n_out_clip  = 1'b1;
                    end else if (r_sum < -w_lim_ext) begin
                        n_out_drive = -$signed({1'b0, r_lim});
                        n_out_clip  = 1'b1;
                    end else begin
                        n_out_drive = r_sum[DW-1:0];
                        n_out_clip  = 1'b0;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control, loop state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= '0;
            r_prev_err  <= '0;
            r_mode      <= fppid_pkg::MODE_PARALLEL;
            r_kp        <= fppid_pkg::RST_PROP_GAIN;
            r_ki        <= fppid_pkg::RST_INTEG_GAIN;
            r_kd        <= fppid_pkg::RST_DERIV_GAIN;
            r_lim       <= fppid_pkg::RST_OUT_LIMIT;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_integ     <= n_integ;
            r_prev_err  <= n_prev_err;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fppid_pkg::REG_MODE:       r_mode <= i_cfg_data[0];
                    fppid_pkg::REG_PROP_GAIN:  r_kp   <= i_cfg_data;
                    fppid_pkg::REG_INTEG_GAIN: r_ki   <= i_cfg_data;
                    fppid_pkg::REG_DERIV_GAIN: r_kd   <= i_cfg_data;
                    fppid_pkg::REG_OUT_LIMIT:  r_lim  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_err       <= n_err;
        r_p         <= n_p;
        r_d         <= n_d;
        r_room      <= n_room;
        r_sum       <= n_sum;
        r_out_drive <= n_out_drive;
        r_out_clip  <= n_out_clip;
    end

    // an accepted beat starts the sequencer
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == S_MP))
        else $error("accepted beat did not start the sequencer");

    // a pending result always stays within the output limit
    a_drive_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed({r_out_drive[DW-1], r_out_drive}) <= $signed({2'b00, r_lim})
                      && $signed({r_out_drive[DW-1], r_out_drive}) >= -$signed({2'b00, r_lim})))
        else $error("drive outside the output limit");

    // a clipped result sits exactly on the limit
    a_clip_on_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clip) |-> (r_out_drive == $signed({1'b0, r_lim})
                                      || r_out_drive == -$signed({1'b0, r_lim})))
        else $error("clipped result not on the limit");

    // series mode never touches the last error
    a_series_keeps_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == fppid_pkg::MODE_SERIES && !i_cfg_we) |=> $stable(r_prev_err))
        else $error("last error changed in series mode");

endmodule
